>>> rtl/tle_pkg.sv
// ----------------------------------------------------------------------------
// tle_pkg
// shared types and constants of the terminal line editor
// ----------------------------------------------------------------------------
package tle_pkg;

	// line and tab geometry
	localparam int MAX_LINE          = 80;
	localparam int TAB_WIDTH_DEF     = 4;
	localparam int QUEUE_DEPTH_DEF   = 2;

	// configuration register indexes
	localparam logic CFG_LINE_CAPACITY = 1'b0;
	localparam logic CFG_START_COLUMN  = 1'b1;

	// configuration reset values
	localparam logic [6:0] LINE_CAPACITY_RST = 7'd80;
	localparam logic [6:0] START_COLUMN_RST  = 7'd0;

	// key codes
	localparam logic [7:0] KEY_BS        = 8'd8;
	localparam logic [7:0] KEY_TAB       = 8'd9;
	localparam logic [7:0] KEY_LF        = 8'd10;
	localparam logic [7:0] KEY_CR        = 8'd13;
	localparam logic [7:0] KEY_LEFT      = 8'd203;
	localparam logic [7:0] KEY_RIGHT     = 8'd205;
	localparam logic [7:0] KEY_PRINT_LO  = 8'd32;
	localparam logic [7:0] KEY_PRINT_HI  = 8'd126;
	localparam logic [7:0] CHAR_SPACE    = 8'd32;

	// key classes decided by the front end
	typedef enum logic [2:0] {
		OP_PRINT,
		OP_ENTER,
		OP_BS,
		OP_TAB,
		OP_LEFT,
		OP_RIGHT,
		OP_NONE
	} tle_op_t;

	typedef struct packed {
		tle_op_t    op;
		logic [7:0] ch;
	} tle_item_t;

	typedef enum logic {
		BK_IDLE,
		BK_TAB
	} tle_back_state_t;

endpackage

>>> rtl/tle_front.sv
// ----------------------------------------------------------------------------
// tle_front
// accepts key events, drops releases and classifies presses
// ----------------------------------------------------------------------------
module tle_front (
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         key_code,
	input  logic               key_pressed,
	output logic               push,
	output tle_pkg::tle_item_t push_item,
	input  logic               q_full
);

	tle_pkg::tle_op_t op;

	always_comb begin
		if (key_code >= tle_pkg::KEY_PRINT_LO && key_code <= tle_pkg::KEY_PRINT_HI) begin
			op = tle_pkg::OP_PRINT;
		end else if (key_code == tle_pkg::KEY_CR || key_code == tle_pkg::KEY_LF) begin
			op = tle_pkg::OP_ENTER;
		end else if (key_code == tle_pkg::KEY_BS) begin
			op = tle_pkg::OP_BS;
		end else if (key_code == tle_pkg::KEY_TAB) begin
			op = tle_pkg::OP_TAB;
		end else if (key_code == tle_pkg::KEY_LEFT) begin
			op = tle_pkg::OP_LEFT;
		end else if (key_code == tle_pkg::KEY_RIGHT) begin
			op = tle_pkg::OP_RIGHT;
		end else begin
			op = tle_pkg::OP_NONE;
		end
	end

	assign in_ready     = !q_full;
	// releases are taken and dropped
	assign push         = in_valid && !q_full && key_pressed;
	assign push_item.op = op;
	assign push_item.ch = key_code;

endmodule

>>> rtl/tle_queue.sv
// ----------------------------------------------------------------------------
// tle_queue
// short queue of classified requests between front and back
// ----------------------------------------------------------------------------
module tle_queue #(
	parameter int DEPTH = tle_pkg::QUEUE_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  tle_pkg::tle_item_t push_item,
	output logic               full,
	input  logic               pop,
	output logic               q_valid,
	output tle_pkg::tle_item_t q_item
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	tle_pkg::tle_item_t entry_q [DEPTH];
	logic [PW-1:0]      wr_ptr_q;
	logic [PW-1:0]      rd_ptr_q;
	logic [CW-1:0]      count_q;

	assign full    = count_q == CW'(DEPTH);
	assign q_valid = count_q != '0;
	assign q_item  = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

>>> rtl/tle_back.sv
// ----------------------------------------------------------------------------
// tle_back
// carries out edit requests, keeps cursor and end mark, registers results
// ----------------------------------------------------------------------------
module tle_back #(
	parameter int TAB_WIDTH = tle_pkg::TAB_WIDTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [6:0]         line_capacity,
	input  logic [6:0]         start_column,
	input  logic               q_valid,
	input  tle_pkg::tle_item_t q_item,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               write_valid,
	output logic [6:0]         write_position,
	output logic [7:0]         write_char,
	output logic [7:0]         cursor_column,
	output logic               line_done,
	output logic               last
);

	localparam int CW = $clog2(TAB_WIDTH + 1);

	tle_pkg::tle_back_state_t state_q, state_d;
	logic [CW-1:0] cnt_q, cnt_d;
	logic [6:0]    cursor_q, cursor_d;
	logic [6:0]    end_q, end_d;

	logic          out_valid_q;
	logic          wv_q, done_q, last_q;
	logic [6:0]    pos_q;
	logic [7:0]    ch_q;
	logic [7:0]    col_q;

	logic          adv, load;
	logic [6:0]    cap;
	logic [6:0]    wr_cursor, wr_end, bs_end;
	logic          tab_fits;
	logic [6:0]    n_cursor, n_end;
	logic          r_wv, r_last, r_enter, r_done;
	logic [6:0]    r_pos;
	logic [7:0]    r_ch;

	// capacity clamped to 1..MAX_LINE
	always_comb begin
		if (line_capacity == 7'd0) begin
			cap = 7'd1;
		end else if (line_capacity > 7'(tle_pkg::MAX_LINE)) begin
			cap = 7'(tle_pkg::MAX_LINE);
		end else begin
			cap = line_capacity;
		end
	end

	assign adv       = !out_valid_q || out_ready;
	assign wr_cursor = cursor_q + 7'd1;
	assign wr_end    = (wr_cursor > end_q) ? wr_cursor : end_q;
	assign bs_end    = (cursor_q == end_q && end_q != 7'd0) ? end_q - 7'd1 : end_q;
	assign tab_fits  = ({1'b0, cursor_q} + 8'(TAB_WIDTH)) < {1'b0, cap};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tle_pkg::BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		pop      = 1'b0;
		load     = 1'b0;
		n_cursor = cursor_q;
		n_end    = end_q;
		r_wv     = 1'b0;
		r_pos    = '0;
		r_ch     = '0;
		r_last   = 1'b1;
		r_enter  = 1'b0;
		case (state_q)
			tle_pkg::BK_IDLE: begin
				if (adv && q_valid) begin
					pop  = 1'b1;
					load = 1'b1;
					case (q_item.op)
						tle_pkg::OP_PRINT: begin
							r_wv     = 1'b1;
							r_pos    = cursor_q;
							r_ch     = q_item.ch;
							n_cursor = wr_cursor;
							n_end    = wr_end;
						end
						tle_pkg::OP_ENTER: begin
							r_wv     = 1'b1;
							r_pos    = cursor_q;
							r_ch     = tle_pkg::KEY_LF;
							n_cursor = wr_cursor;
							n_end    = wr_end;
							r_enter  = 1'b1;
						end
						tle_pkg::OP_BS: begin
							n_end = bs_end;
							if (cursor_q != 7'd0) begin
								n_cursor = cursor_q - 7'd1;
								r_wv     = 1'b1;
								r_pos    = cursor_q - 7'd1;
								r_ch     = tle_pkg::CHAR_SPACE;
							end
						end
						tle_pkg::OP_TAB: begin
							if (tab_fits) begin
								r_wv     = 1'b1;
								r_pos    = cursor_q;
								r_ch     = tle_pkg::CHAR_SPACE;
								n_cursor = wr_cursor;
								n_end    = wr_end;
								if (TAB_WIDTH > 1) begin
									r_last  = 1'b0;
									cnt_d   = CW'(TAB_WIDTH - 1);
									state_d = tle_pkg::BK_TAB;
								end
							end
						end
						tle_pkg::OP_LEFT: begin
							if (cursor_q != 7'd0) begin
								n_cursor = cursor_q - 7'd1;
							end
						end
						tle_pkg::OP_RIGHT: begin
							if (cursor_q < end_q) begin
								n_cursor = wr_cursor;
							end
						end
						default: begin
						end
					endcase
				end
			end
			tle_pkg::BK_TAB: begin
				// remaining spaces of a tab, one per result
				if (adv) begin
					load     = 1'b1;
					r_wv     = 1'b1;
					r_pos    = cursor_q;
					r_ch     = tle_pkg::CHAR_SPACE;
					n_cursor = wr_cursor;
					n_end    = wr_end;
					cnt_d    = cnt_q - CW'(1);
					r_last   = cnt_q == CW'(1);
					if (cnt_q == CW'(1)) begin
						state_d = tle_pkg::BK_IDLE;
					end
				end
			end
			default: begin
				state_d = tle_pkg::BK_IDLE;
			end
		endcase
		r_done   = r_last && (r_enter || n_cursor >= cap);
		cursor_d = cursor_q;
		end_d    = end_q;
		if (load) begin
			cursor_d = r_done ? 7'd0 : n_cursor;
			end_d    = r_done ? 7'd0 : n_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_q    <= '0;
			end_q       <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			cursor_q <= cursor_d;
			end_q    <= end_d;
			cnt_q    <= cnt_d;
			if (adv) begin
				out_valid_q <= load;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			wv_q   <= r_wv;
			pos_q  <= r_pos;
			ch_q   <= r_ch;
			col_q  <= {1'b0, start_column} + {1'b0, n_cursor};
			done_q <= r_done;
			last_q <= r_last;
		end
	end

	assign out_valid      = out_valid_q;
	assign write_valid    = wv_q;
	assign write_position = pos_q;
	assign write_char     = ch_q;
	assign cursor_column  = col_q;
	assign line_done      = done_q;
	assign last           = last_q;

endmodule

>>> rtl/terminal_line_editor_unit.sv
// ----------------------------------------------------------------------------
// terminal_line_editor_unit
// one-line keyboard editor: key events in, cell writes and cursor moves out
// ----------------------------------------------------------------------------
// Each key press produces one or more results on the output channel; key
// releases are taken and produce nothing. A printable key, enter or a
// backspace that moves gives one write result, a tab that fits gives
// TAB_WIDTH write results, and every other press gives one result that only
// reports the cursor; the final result of a press has last set, and
// line_done when that press ended the line. The back end emits one result
// per cycle through its output register unless out_ready stalls it; the
// front end keeps taking key requests into a QUEUE_DEPTH entry queue while
// it has room, also as the back end works or the output stalls. The user
// must write configuration (index 0 line_capacity, index 1 start_column)
// via cfg_we/cfg_index/cfg_wdata while no request is in flight (not enforced).
// ----------------------------------------------------------------------------
module terminal_line_editor_unit #(
	parameter int TAB_WIDTH   = tle_pkg::TAB_WIDTH_DEF,
	parameter int QUEUE_DEPTH = tle_pkg::QUEUE_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	// configuration write port
	input  logic       cfg_we,
	input  logic       cfg_index,
	input  logic [6:0] cfg_wdata,
	// key requests
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] key_code,
	input  logic       key_pressed,
	// results
	output logic       out_valid,
	input  logic       out_ready,
	output logic       write_valid,
	output logic [6:0] write_position,
	output logic [7:0] write_char,
	output logic [7:0] cursor_column,
	output logic       line_done,
	output logic       last
);

	logic [6:0]         line_capacity_q;
	logic [6:0]         start_column_q;

	logic               push;
	tle_pkg::tle_item_t push_item;
	logic               q_full;
	logic               pop;
	logic               q_valid;
	tle_pkg::tle_item_t q_item;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_capacity_q <= tle_pkg::LINE_CAPACITY_RST;
			start_column_q  <= tle_pkg::START_COLUMN_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				tle_pkg::CFG_LINE_CAPACITY: line_capacity_q <= cfg_wdata;
				tle_pkg::CFG_START_COLUMN:  start_column_q  <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	// front: take and classify key events
	tle_front u_front (
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.key_code    (key_code),
		.key_pressed (key_pressed),
		.push        (push),
		.push_item   (push_item),
		.q_full      (q_full)
	);

	// queue decouples the two sides
	tle_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (pop),
		.q_valid   (q_valid),
		.q_item    (q_item)
	);

	// back: edit state and result register
	tle_back #(
		.TAB_WIDTH (TAB_WIDTH)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.line_capacity  (line_capacity_q),
		.start_column   (start_column_q),
		.q_valid        (q_valid),
		.q_item         (q_item),
		.pop            (pop),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.write_valid    (write_valid),
		.write_position (write_position),
		.write_char     (write_char),
		.cursor_column  (cursor_column),
		.line_done      (line_done),
		.last           (last)
	);

endmodule

>>> test/line_edit_checker.sv
// ----------------------------------------------------------------------------
// line_edit_checker
// watches the key and result channels of the terminal line editor, works out
// the cell writes and cursor reports each key press must give, and compares
// every result field by field in order
// ----------------------------------------------------------------------------
module line_edit_checker #(
	parameter int TAB_W = tle_pkg::TAB_WIDTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_index,
	input  logic [6:0] cfg_wdata,
	input  logic       in_valid,
	input  logic       in_ready,
	input  logic [7:0] key_code,
	input  logic       key_pressed,
	input  logic       out_valid,
	input  logic       out_ready,
	input  logic       write_valid,
	input  logic [6:0] write_position,
	input  logic [7:0] write_char,
	input  logic [7:0] cursor_column,
	input  logic       line_done,
	input  logic       last,
	output int         fail_count,
	output int         pending,
	output int         results_checked,
	output int         lines_ended
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic       wr;
		logic [6:0] pos;
		logic [7:0] ch;
		logic [7:0] col;
		logic       done;
		logic       fin;
	} edit_t;

	edit_t      expected_edits[$];
	edit_t      press_edits[TAB_W + 1];
	int         press_n;
	edit_t      head;
	logic [6:0] line_cap;
	logic [6:0] start_col;
	logic [6:0] cursor;
	logic [6:0] end_mark;

	// screen column reported with each result
	function automatic logic [7:0] screen_col();
		return {1'b0, start_col} + {1'b0, cursor};
	endfunction

	// one cell write at the cursor; the end mark follows the cursor forward
	task automatic put_cell(input logic [7:0] ch);
		edit_t e;
		e = '0;
		e.wr = 1'b1;
		e.pos = cursor;
		e.ch = ch;
		cursor = cursor + 7'd1;
		if (cursor > end_mark)
			end_mark = cursor;
		e.col = screen_col();
		press_edits[press_n] = e;
		press_n++;
	endtask

	// edit state update for one key press, queueing the results it gives
	task automatic apply_key(input logic [7:0] code);
		int    cap;
		logic  ended;
		edit_t e;
		int    i;
		cap = (line_cap == 7'd0) ? 1 :
			(int'(line_cap) > tle_pkg::MAX_LINE) ? tle_pkg::MAX_LINE : int'(line_cap);
		ended = 1'b0;
		press_n = 0;
		if (code >= tle_pkg::KEY_PRINT_LO && code <= tle_pkg::KEY_PRINT_HI) begin
			put_cell(code);
		end else if (code == tle_pkg::KEY_CR || code == tle_pkg::KEY_LF) begin
			put_cell(tle_pkg::KEY_LF);
			ended = 1'b1;
		end else if (code == tle_pkg::KEY_BS) begin
			if (cursor == end_mark && end_mark != 7'd0)
				end_mark = end_mark - 7'd1;
			if (cursor != 7'd0) begin
				cursor = cursor - 7'd1;
				e = '0;
				e.wr = 1'b1;
				e.pos = cursor;
				e.ch = tle_pkg::CHAR_SPACE;
				e.col = screen_col();
				press_edits[0] = e;
				press_n = 1;
			end
		end else if (code == tle_pkg::KEY_TAB) begin
			if (int'(cursor) + TAB_W < cap)
				for (i = 0; i < TAB_W; i++)
					put_cell(tle_pkg::CHAR_SPACE);
		end else if (code == tle_pkg::KEY_LEFT) begin
			if (cursor != 7'd0)
				cursor = cursor - 7'd1;
		end else if (code == tle_pkg::KEY_RIGHT) begin
			if (cursor < end_mark)
				cursor = cursor + 7'd1;
		end
		// nothing written: a single cursor report
		if (press_n == 0) begin
			e = '0;
			e.col = screen_col();
			press_edits[0] = e;
			press_n = 1;
		end
		if (int'(cursor) >= cap)
			ended = 1'b1;
		press_edits[press_n - 1].fin = 1'b1;
		press_edits[press_n - 1].done = ended;
		if (ended) begin
			cursor = '0;
			end_mark = '0;
		end
		for (i = 0; i < press_n; i++)
			expected_edits.push_back(press_edits[i]);
	endtask

	task automatic check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$display("%t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_edits.delete();
			line_cap = tle_pkg::LINE_CAPACITY_RST;
			start_col = tle_pkg::START_COLUMN_RST;
			cursor = '0;
			end_mark = '0;
			fail_count = 0;
			pending = 0;
			results_checked = 0;
			lines_ended = 0;
		end else begin
			// results first: nothing taken at this edge can already be answered
			if (out_valid && out_ready) begin
				if (expected_edits.size() == 0) begin
					$display("%t: unexpected result, actual wr=%0d pos=%0d ch=%0d col=%0d done=%0d last=%0d",
						$time, write_valid, write_position, write_char, cursor_column,
						line_done, last);
					fail_count++;
				end else begin
					head = expected_edits.pop_front();
					check_field("write_valid", head.wr, write_valid);
					check_field("write_position", head.pos, write_position);
					check_field("write_char", head.ch, write_char);
					check_field("cursor_column", head.col, cursor_column);
					check_field("line_done", head.done, line_done);
					check_field("last", head.fin, last);
					results_checked++;
					if (head.done)
						lines_ended++;
				end
			end
			if (in_valid && in_ready && key_pressed)
				apply_key(key_code);
			if (cfg_we) begin
				if (cfg_index == tle_pkg::CFG_LINE_CAPACITY)
					line_cap = cfg_wdata;
				else
					start_col = cfg_wdata;
			end
			pending = expected_edits.size();
		end
	end

endmodule

>>> test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// key event stimulus and verdict for the terminal line editor
// ----------------------------------------------------------------------------
// A short directed sequence walks the edge cases of line editing (arrows and
// backspace at the line limits, tabs that do and do not fit, unknown codes,
// out of range capacities, a capacity lowered mid-line), then random phases
// under several register settings type mixed key streams. The sender works
// in bursts with gaps, the receiver stalls on its own pattern, and one long
// receiver hold-off backs the block up. line_edit_checker does all checking.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG_LIMIT = 2000;	// cycles with no request moving
	localparam int DRAIN_CYCLES   = 24;	// queue depth plus a tab, with margin
	localparam int LONG_STALL     = 80;	// receiver hold-off to fill the block
	localparam int PHASES         = 6;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_we = 1'b0;
	logic       cfg_index = 1'b0;
	logic [6:0] cfg_wdata = '0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [7:0] key_code = '0;
	logic       key_pressed = 1'b0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic       write_valid;
	logic [6:0] write_position;
	logic [7:0] write_char;
	logic [7:0] cursor_column;
	logic       line_done;
	logic       last;

	int fail_count;
	int pending;
	int results_checked;
	int lines_ended;

	int presses_sent = 0;
	int releases_sent = 0;
	int burst_left = 0;
	int idle_cycles = 0;

	// receiver state
	bit long_stall_req = 1'b0;
	int hold_left = 0;
	int ready_mode = 0;
	int mode_left = 0;

	terminal_line_editor_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.key_code      (key_code),
		.key_pressed   (key_pressed),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.write_valid   (write_valid),
		.write_position(write_position),
		.write_char    (write_char),
		.cursor_column (cursor_column),
		.line_done     (line_done),
		.last          (last)
	);

	line_edit_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_wdata      (cfg_wdata),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.key_code       (key_code),
		.key_pressed    (key_pressed),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.write_valid    (write_valid),
		.write_position (write_position),
		.write_char     (write_char),
		.cursor_column  (cursor_column),
		.line_done      (line_done),
		.last           (last),
		.fail_count     (fail_count),
		.pending        (pending),
		.results_checked(results_checked),
		.lines_ended    (lines_ended)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// receiver: random ready modes, with a long hold-off on request
	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else if (long_stall_req) begin
			long_stall_req = 1'b0;
			hold_left = LONG_STALL - 1;
			out_ready <= 1'b0;
		end else begin
			if (mode_left == 0) begin
				ready_mode = $urandom_range(0, 3);
				mode_left = $urandom_range(16, 80);
			end
			mode_left--;
			case (ready_mode)
				0: out_ready <= 1'b1;			// no stalls at all
				1: out_ready <= ($urandom_range(0, 3) != 0);
				2: out_ready <= ($urandom_range(0, 3) == 0);	// mostly stalled
				default: out_ready <= ~out_ready;	// alternating ready
			endcase
		end
	end

	// offer one key request and hold it until taken; called at a falling edge
	task automatic offer_key(input logic [7:0] code, input logic pressed);
		in_valid <= 1'b1;
		key_code <= code;
		key_pressed <= pressed;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		@(negedge clk);
		if (pressed)
			presses_sent++;
		else
			releases_sent++;
		// bursts of random length, some long ones with no gaps
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8))
				@(negedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(0, 10);
		end
	endtask

	// stop offering and let every queued request and every result drain
	task automatic settle_idle();
		in_valid <= 1'b0;
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES)
			@(negedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [6:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic configure(input logic [6:0] cap, input logic [6:0] col);
		settle_idle();
		write_reg(tle_pkg::CFG_LINE_CAPACITY, cap);
		write_reg(tle_pkg::CFG_START_COLUMN, col);
	endtask

	// random key with a given share of printable characters
	function automatic logic [7:0] pick_key(input int print_pct);
		if ($urandom_range(0, 99) < print_pct)
			return 8'($urandom_range(32, 126));
		case ($urandom_range(0, 9))
			0, 1: return tle_pkg::KEY_BS;
			2: return tle_pkg::KEY_TAB;
			3, 4: return tle_pkg::KEY_LEFT;
			5, 6: return tle_pkg::KEY_RIGHT;
			7: return $urandom_range(0, 1) ? tle_pkg::KEY_CR : tle_pkg::KEY_LF;
			8: return 8'($urandom_range(0, 255));	// anything, mostly unknown
			default: return 8'($urandom_range(0, 31));	// control codes
		endcase
	endfunction

	// stall watchdog
	initial begin
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("%t: watchdog, no request moved for %0d cycles", $time, WATCHDOG_LIMIT);
		$display("Some tests failed");
		$finish;
	end

	initial begin
		int ph;
		int n;
		int presses;
		int print_pct;
		logic [6:0] cap;
		logic [6:0] col;

		repeat (4)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed part at reset settings: capacity 80, start column 0
		offer_key(8'h41, 1'b0);			// a release gives nothing
		offer_key(8'h00, 1'b1);			// unknown code, all bits low
		offer_key(tle_pkg::KEY_BS, 1'b1);	// backspace at column zero
		offer_key(tle_pkg::KEY_LEFT, 1'b1);	// left at zero
		offer_key(tle_pkg::KEY_RIGHT, 1'b1);	// right at an empty end mark
		offer_key(8'd32, 1'b1);			// lowest printable
		offer_key(8'h41, 1'b1);
		offer_key(8'd126, 1'b1);		// highest printable
		offer_key(tle_pkg::KEY_RIGHT, 1'b1);	// right at the end mark
		offer_key(tle_pkg::KEY_LEFT, 1'b1);
		offer_key(tle_pkg::KEY_BS, 1'b1);	// backspace inside the line
		offer_key(tle_pkg::KEY_RIGHT, 1'b1);
		offer_key(tle_pkg::KEY_RIGHT, 1'b1);
		offer_key(tle_pkg::KEY_BS, 1'b1);	// backspace at the end mark
		offer_key(tle_pkg::KEY_TAB, 1'b1);	// tab that fits
		offer_key(8'hff, 1'b1);			// unknown code, all bits high
		offer_key(tle_pkg::KEY_CR, 1'b1);	// carriage return ends the line

		// tiny line: tab fills to the edge, a key fills the line, tab too long
		configure(7'd5, 7'd79);
		offer_key(tle_pkg::KEY_TAB, 1'b1);
		offer_key(8'h78, 1'b1);
		offer_key(8'h79, 1'b1);
		offer_key(tle_pkg::KEY_TAB, 1'b1);
		offer_key(tle_pkg::KEY_LF, 1'b1);	// line feed ends the line

		// capacity zero acts as one, widest start column
		configure(7'd0, 7'd127);
		offer_key(8'h61, 1'b1);
		offer_key(tle_pkg::KEY_TAB, 1'b1);

		// capacity lowered under a cursor in the middle of a line
		configure(7'd80, 7'd0);
		offer_key(tle_pkg::KEY_TAB, 1'b1);
		settle_idle();
		write_reg(tle_pkg::CFG_LINE_CAPACITY, 7'd3);
		offer_key(tle_pkg::KEY_LEFT, 1'b1);

		// random phases, each under its own register setting
		for (ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: begin cap = 7'd80; col = 7'd0; print_pct = 90; presses = 56; end
				1: begin cap = 7'd127; col = 7'd127; print_pct = 60; presses = 26; end
				2: begin cap = 7'd0; col = 7'd79; print_pct = 50; presses = 26; end
				3: begin cap = 7'd1; col = 7'd5; print_pct = 40; presses = 26; end
				4: begin
					cap = 7'($urandom_range(2, 12));
					col = 7'($urandom_range(0, 79));
					print_pct = 50;
					presses = 26;
				end
				default: begin
					cap = 7'd40;
					col = 7'($urandom_range(0, 127));
					print_pct = 55;
					presses = 26;
				end
			endcase
			configure(cap, col);
			// long receiver hold-off while keys keep coming
			if (ph == 1)
				long_stall_req = 1'b1;
			n = 0;
			while (n < presses) begin
				if ($urandom_range(0, 19) == 0) begin
					offer_key(8'($urandom_range(0, 255)), 1'b0);
				end else begin
					offer_key(pick_key(print_pct), 1'b1);
					n++;
				end
			end
		end

		settle_idle();
		$display("covered %0d key presses and %0d releases over %0d register settings",
			presses_sent, releases_sent, PHASES + 5);
		$display("checked %0d results, %0d lines ended", results_checked, lines_ended);
		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
